FILE: hw/rtl/fba_pkg.sv
// ----------------------------------------------------------------------------
// fba_pkg
// shared types, constants and the microcode encoding for the fader automation
// ----------------------------------------------------------------------------
package fba_pkg;

  localparam int NUM_POINTS  = 8;
  localparam int PT_W        = $clog2(NUM_POINTS);
  localparam int LVL_W       = 8;
  localparam int CUR_W       = 16;
  localparam int STEP_W      = 17;
  localparam int TIME_SCALE  = 10;
  localparam int DIVD_W      = 24;
  localparam int DIVS_W      = 12;
  localparam int CNT_W       = $clog2(DIVD_W + 1);
  localparam int PC_W        = 5;
  localparam int CFG_W       = 64;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVELS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VALUES = 2'd2;

  localparam logic OPC_FULL = 1'b0;
  localparam logic OPC_SUB  = 1'b1;

  typedef enum logic [1:0] {
    MODE_OFF     = 2'd0,
    MODE_PHASE   = 2'd1,
    MODE_ENV     = 2'd2,
    MODE_ENV_ALT = 2'd3
  } mode_t;

  // datapath operations, one per microcode step
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LATCH,
    OP_UPDLAST,
    OP_PHASE,
    OP_SRCH_INIT,
    OP_SRCH,
    OP_EDGE,
    OP_MUL,
    OP_SCALE,
    OP_IDIV,
    OP_INTERP,
    OP_DIFF,
    OP_STEP,
    OP_EMIT
  } uop_t;

  // jump conditions
  typedef enum logic [3:0] {
    C_NEXT,
    C_ALWAYS,
    C_NOSTART,
    C_NOCHANGE,
    C_ENV,
    C_NOISSUE,
    C_SRCH_CONT,
    C_EDGE,
    C_DIV_BUSY,
    C_DIFF_DONE,
    C_OUT_FULL
  } cond_t;

  typedef struct packed {
    uop_t            op;
    cond_t           cond;
    logic [PC_W-1:0] jmp;
    logic            last;
  } ctrl_word_t;

  typedef struct packed {
    logic start;
    logic nochange;
    logic env;
    logic noissue;
    logic srch_cont;
    logic edge_hit;
    logic div_busy;
    logic diff_done;
    logic out_full;
  } stat_t;

  // program addresses
  localparam logic [PC_W-1:0] A_WAIT      = 5'd0;
  localparam logic [PC_W-1:0] A_CHECK     = 5'd1;
  localparam logic [PC_W-1:0] A_UPDLAST   = 5'd2;
  localparam logic [PC_W-1:0] A_PHASE     = 5'd3;
  localparam logic [PC_W-1:0] A_PH_JUMP   = 5'd4;
  localparam logic [PC_W-1:0] A_SRCH_INIT = 5'd5;
  localparam logic [PC_W-1:0] A_SRCH      = 5'd6;
  localparam logic [PC_W-1:0] A_EDGE      = 5'd7;
  localparam logic [PC_W-1:0] A_MUL       = 5'd8;
  localparam logic [PC_W-1:0] A_SCALE     = 5'd9;
  localparam logic [PC_W-1:0] A_IDIV      = 5'd10;
  localparam logic [PC_W-1:0] A_IWAIT     = 5'd11;
  localparam logic [PC_W-1:0] A_INTERP    = 5'd12;
  localparam logic [PC_W-1:0] A_DIFF      = 5'd13;
  localparam logic [PC_W-1:0] A_SWAIT     = 5'd14;
  localparam logic [PC_W-1:0] A_STEP      = 5'd15;
  localparam logic [PC_W-1:0] A_EMIT      = 5'd16;

  // byte of a packed point register, point index from 0
  function automatic logic [LVL_W-1:0] pt_byte(input logic [CFG_W-1:0] r,
                                               input logic [PT_W-1:0] i);
    return r[{i, 3'b000} +: LVL_W];
  endfunction

endpackage

FILE: hw/rtl/fba_ucode_rom.sv
// ----------------------------------------------------------------------------
// fba_ucode_rom
// control store: one control word per program step
// ----------------------------------------------------------------------------
module fba_ucode_rom import fba_pkg::*; (
  input  logic [PC_W-1:0] pc,
  output ctrl_word_t      ctrl
);

  always_comb begin
    unique case (pc)
      A_WAIT:      ctrl = '{op: OP_LATCH,     cond: C_NOSTART,   jmp: A_WAIT,      last: 1'b0};
      A_CHECK:     ctrl = '{op: OP_NOP,       cond: C_NOCHANGE,  jmp: A_EMIT,      last: 1'b0};
      A_UPDLAST:   ctrl = '{op: OP_UPDLAST,   cond: C_ENV,       jmp: A_SRCH_INIT, last: 1'b0};
      A_PHASE:     ctrl = '{op: OP_PHASE,     cond: C_NOISSUE,   jmp: A_EMIT,      last: 1'b0};
      A_PH_JUMP:   ctrl = '{op: OP_NOP,       cond: C_ALWAYS,    jmp: A_DIFF,      last: 1'b0};
      A_SRCH_INIT: ctrl = '{op: OP_SRCH_INIT, cond: C_NEXT,      jmp: A_WAIT,      last: 1'b0};
      A_SRCH:      ctrl = '{op: OP_SRCH,      cond: C_SRCH_CONT, jmp: A_SRCH,      last: 1'b0};
      A_EDGE:      ctrl = '{op: OP_EDGE,      cond: C_EDGE,      jmp: A_DIFF,      last: 1'b0};
      A_MUL:       ctrl = '{op: OP_MUL,       cond: C_NEXT,      jmp: A_WAIT,      last: 1'b0};
      A_SCALE:     ctrl = '{op: OP_SCALE,     cond: C_NEXT,      jmp: A_WAIT,      last: 1'b0};
      A_IDIV:      ctrl = '{op: OP_IDIV,      cond: C_NEXT,      jmp: A_WAIT,      last: 1'b0};
      A_IWAIT:     ctrl = '{op: OP_NOP,       cond: C_DIV_BUSY,  jmp: A_IWAIT,     last: 1'b0};
      A_INTERP:    ctrl = '{op: OP_INTERP,    cond: C_NEXT,      jmp: A_WAIT,      last: 1'b0};
      A_DIFF:      ctrl = '{op: OP_DIFF,      cond: C_DIFF_DONE, jmp: A_EMIT,      last: 1'b0};
      A_SWAIT:     ctrl = '{op: OP_NOP,       cond: C_DIV_BUSY,  jmp: A_SWAIT,     last: 1'b0};
      A_STEP:      ctrl = '{op: OP_STEP,      cond: C_NEXT,      jmp: A_WAIT,      last: 1'b0};
      A_EMIT:      ctrl = '{op: OP_EMIT,      cond: C_OUT_FULL,  jmp: A_EMIT,      last: 1'b1};
      default:     ctrl = '{op: OP_NOP,       cond: C_ALWAYS,    jmp: A_WAIT,      last: 1'b0};
    endcase
  end

endmodule

FILE: hw/rtl/fba_div.sv
// ----------------------------------------------------------------------------
// fba_div
// unsigned radix-2 restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module fba_div import fba_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [DIVS_W-1:0] divisor,
  output logic              busy,
  output logic [DIVD_W-1:0] quotient
);

  logic [DIVS_W-1:0] rem;
  logic [DIVS_W-1:0] dvs;
  logic [CNT_W-1:0]  cnt;
  logic [DIVS_W:0]   sh;
  logic [DIVS_W:0]   sub;
  logic              ge;

  assign sh   = {rem, quotient[DIVD_W-1]};
  assign sub  = sh - {1'b0, dvs};
  assign ge   = sh >= {1'b0, dvs};
  assign busy = cnt != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= CNT_W'(DIVD_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      // remainder stays below the divisor, so it fits back in DIVS_W bits
      rem      <= ge ? sub[DIVS_W-1:0] : sh[DIVS_W-1:0];
      quotient <= {quotient[DIVD_W-2:0], ge};
    end
  end

endmodule

FILE: hw/rtl/fba_datapath.sv
// ----------------------------------------------------------------------------
// fba_datapath
// registers, breakpoint search, interpolation and step arithmetic
// ----------------------------------------------------------------------------
module fba_datapath import fba_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  uop_t                     op,
  output stat_t                    stat,
  input  logic                     cfg_en,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic                     in_valid,
  input  logic                     opcode,
  input  logic [3:0]               phase,
  input  logic [7:0]               env_position,
  input  logic [7:0]               env_position_alt,
  input  logic [CUR_W-1:0]         current_level,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     update,
  output logic [CUR_W-1:0]         target_level,
  output logic signed [STEP_W-1:0] step,
  output logic                     snap,
  output logic                     phase_clear
);

  mode_t                    mode;
  logic [CFG_W-1:0]         levels;
  logic [CFG_W-1:0]         values;
  logic [7:0]               last_position;

  logic                     opc_r;
  logic [3:0]               phase_r;
  logic [7:0]               pos1_r;
  logic [7:0]               pos2_r;
  logic [CUR_W-1:0]         cur_r;

  logic [PT_W-1:0]          k;
  logic                     found;
  logic signed [17:0]       prod;
  logic signed [24:0]       t257;
  logic [CUR_W-1:0]         target;
  logic [7:0]               time_r;
  logic                     qneg;
  logic                     res_upd;
  logic                     res_clr;
  logic                     res_snap;
  logic signed [STEP_W-1:0] res_step;

  logic [7:0]               sel_pos;
  logic [PT_W-1:0]          kp;
  logic [PT_W-1:0]          ph_idx;
  logic                     hit;
  logic signed [8:0]        dpos;
  logic signed [8:0]        dlvl;
  logic signed [STEP_W-1:0] diff;
  logic [CUR_W-1:0]         diff_mag;
  logic [DIVD_W-1:0]        t_mag;
  logic [DIVS_W-1:0]        time_div;
  logic [LVL_W-1:0]         seg_div;
  logic                     div_load;
  logic                     div_busy;
  logic [DIVD_W-1:0]        quo;
  logic [CUR_W-1:0]         q16;
  logic signed [STEP_W-1:0] q_signed;
  logic [LVL_W-1:0]         lprev;
  logic [STEP_W-1:0]        interp_sum;
  logic                     out_free;

  assign sel_pos  = (mode == MODE_PHASE) ? {4'b0000, phase_r} :
                    (mode == MODE_ENV)   ? pos1_r : pos2_r;
  assign kp       = k - 1'b1;
  assign ph_idx   = PT_W'(phase_r - 4'd1);
  assign hit      = sel_pos >= pt_byte(values, k);
  assign dpos     = $signed({1'b0, sel_pos}) - $signed({1'b0, pt_byte(values, kp)});
  assign dlvl     = $signed({1'b0, pt_byte(levels, k)}) - $signed({1'b0, pt_byte(levels, kp)});
  assign diff     = $signed({1'b0, target}) - $signed({1'b0, cur_r});
  assign diff_mag = diff[STEP_W-1] ? CUR_W'(-diff) : diff[CUR_W-1:0];
  assign t_mag    = t257[24] ? DIVD_W'(-t257) : t257[DIVD_W-1:0];
  assign time_div = DIVS_W'(time_r) * DIVS_W'(TIME_SCALE);
  // within the chosen segment the earlier breakpoint is above the later one
  assign seg_div  = pt_byte(values, kp) - pt_byte(values, k);
  assign q16      = quo[CUR_W-1:0];
  assign q_signed = qneg ? -$signed({1'b0, q16}) : $signed({1'b0, q16});
  assign lprev    = pt_byte(levels, kp);
  assign interp_sum = $signed({1'b0, lprev, lprev}) + q_signed;
  assign out_free = !out_valid || out_ready;

  assign div_load = (op == OP_IDIV) ||
                    (op == OP_DIFF && diff != '0 && time_r != '0);

  fba_div u_div (
    .clk      (clk),
    .rst      (rst),
    .load     (div_load),
    .dividend (op == OP_IDIV ? t_mag : DIVD_W'(diff_mag)),
    .divisor  (op == OP_IDIV ? DIVS_W'(seg_div) : time_div),
    .busy     (div_busy),
    .quotient (quo)
  );

  always_comb begin
    stat.start     = in_valid;
    stat.nochange  = (mode == MODE_OFF) || (mode == MODE_PHASE && opc_r == OPC_SUB) ||
                     (sel_pos == last_position);
    stat.env       = mode[1];
    stat.noissue   = (phase_r == '0) || (phase_r > 4'(NUM_POINTS));
    stat.srch_cont = !hit && (k != PT_W'(NUM_POINTS - 1));
    stat.edge_hit  = !found || (k == '0);
    stat.div_busy  = div_busy;
    stat.diff_done = (diff == '0) || (time_r == '0);
    stat.out_full  = !out_free;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_OFF;
      levels        <= '0;
      values        <= '0;
      last_position <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_en) begin
        case (cfg_index)
          CFG_MODE:   mode   <= mode_t'(cfg_data[1:0]);
          CFG_LEVELS: levels <= cfg_data;
          CFG_VALUES: values <= cfg_data;
          default:    ;
        endcase
      end
      if (op == OP_UPDLAST) begin
        last_position <= sel_pos;
      end
      if (op == OP_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    case (op)
      OP_LATCH: begin
        if (in_valid) begin
          opc_r    <= opcode;
          phase_r  <= phase;
          pos1_r   <= env_position;
          pos2_r   <= env_position_alt;
          cur_r    <= current_level;
          res_upd  <= 1'b0;
          res_clr  <= 1'b0;
          res_snap <= 1'b0;
          res_step <= '0;
          target   <= '0;
        end
      end
      OP_PHASE: begin
        if (phase_r > 4'(NUM_POINTS)) begin
          res_clr <= 1'b1;
        end else if (phase_r != '0) begin
          res_upd <= 1'b1;
          target  <= {pt_byte(levels, ph_idx), pt_byte(levels, ph_idx)};
          time_r  <= pt_byte(values, ph_idx);
        end
      end
      OP_SRCH_INIT: begin
        k       <= '0;
        time_r  <= 8'd1;
        res_upd <= 1'b1;
      end
      OP_SRCH: begin
        found <= hit;
        if (!hit && k != PT_W'(NUM_POINTS - 1)) begin
          k <= k + 1'b1;
        end
      end
      OP_EDGE: begin
        // first breakpoint or below all: level of point k scaled by 257
        target <= {pt_byte(levels, k), pt_byte(levels, k)};
      end
      OP_MUL: begin
        prod <= dpos * dlvl;
      end
      OP_SCALE: begin
        t257 <= ({{7{prod[17]}}, prod} <<< 8) + {{7{prod[17]}}, prod};
      end
      OP_IDIV: begin
        // divisor is negative, so the quotient takes the opposite sign
        qneg <= !t257[24];
      end
      OP_INTERP: begin
        target <= interp_sum[CUR_W-1:0];
      end
      OP_DIFF: begin
        qneg <= diff[STEP_W-1];
        if (diff != '0 && time_r == '0) begin
          res_snap <= 1'b1;
        end
      end
      OP_STEP: begin
        res_step <= (q16 == '0) ? STEP_W'(1) : q_signed;
      end
      OP_EMIT: begin
        if (out_free) begin
          update       <= res_upd;
          target_level <= target;
          step         <= res_step;
          snap         <= res_snap;
          phase_clear  <= res_clr;
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: hw/rtl/breakpoint_fader_automation.sv
// ----------------------------------------------------------------------------
// breakpoint_fader_automation
// per-track fader automation: phase targets and breakpoint envelope, run by
// a microcoded sequencer over a shared iterative divider
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  input     in_valid / in_ready    opcode phase env_position env_position_alt
//                                   current_level
//  output    out_valid / out_ready  update target_level step snap phase_clear
//  config    cfg_en                 cfg_index cfg_data
//
//  one transaction at a time; in_ready is high only at the wait step
//  no change or mode off: straight to emit; phase zero or phase clear: emit
//  after the phase step; phase issue: a step is divided out unless the level
//  is already at target or the time is zero; envelope: the breakpoint search
//  (one point a cycle) then up to two divider passes, interpolation and step
//  a result waits in the output register; the sequencer stalls at its emit
//  step only while that register is still full
//  rst is synchronous and clears mode, point registers and last position
// ----------------------------------------------------------------------------
module breakpoint_fader_automation import fba_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_en,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     opcode,
  input  logic [3:0]               phase,
  input  logic [7:0]               env_position,
  input  logic [7:0]               env_position_alt,
  input  logic [CUR_W-1:0]         current_level,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     update,
  output logic [CUR_W-1:0]         target_level,
  output logic signed [STEP_W-1:0] step,
  output logic                     snap,
  output logic                     phase_clear
);

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  ctrl_word_t      ctrl;
  stat_t           stat;
  logic            take;

  fba_ucode_rom u_rom (
    .pc   (pc),
    .ctrl (ctrl)
  );

  always_comb begin
    case (ctrl.cond)
      C_NEXT:      take = 1'b0;
      C_ALWAYS:    take = 1'b1;
      C_NOSTART:   take = !stat.start;
      C_NOCHANGE:  take = stat.nochange;
      C_ENV:       take = stat.env;
      C_NOISSUE:   take = stat.noissue;
      C_SRCH_CONT: take = stat.srch_cont;
      C_EDGE:      take = stat.edge_hit;
      C_DIV_BUSY:  take = stat.div_busy;
      C_DIFF_DONE: take = stat.diff_done;
      C_OUT_FULL:  take = stat.out_full;
      default:     take = 1'b0;
    endcase
    if (take) begin
      pc_next = ctrl.jmp;
    end else if (ctrl.last) begin
      pc_next = A_WAIT;
    end else begin
      pc_next = pc + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= A_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

  assign in_ready = (pc == A_WAIT);

  fba_datapath u_dp (
    .clk              (clk),
    .rst              (rst),
    .op               (ctrl.op),
    .stat             (stat),
    .cfg_en           (cfg_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .opcode           (opcode),
    .phase            (phase),
    .env_position     (env_position),
    .env_position_alt (env_position_alt),
    .current_level    (current_level),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .update           (update),
    .target_level     (target_level),
    .step             (step),
    .snap             (snap),
    .phase_clear      (phase_clear)
  );

endmodule

FILE: hw/rtl/fba_checker.sv
// ----------------------------------------------------------------------------
// fba_checker
// port-level checks on the fader automation, bound to the top level
// ----------------------------------------------------------------------------
module fba_checker import fba_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     cfg_en,
  input logic [CFG_IDX_W-1:0]     cfg_index,
  input logic [CFG_W-1:0]         cfg_data,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     opcode,
  input logic [3:0]               phase,
  input logic [7:0]               env_position,
  input logic [7:0]               env_position_alt,
  input logic [CUR_W-1:0]         current_level,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic                     update,
  input logic [CUR_W-1:0]         target_level,
  input logic signed [STEP_W-1:0] step,
  input logic                     snap,
  input logic                     phase_clear
);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(target_level) && $stable(step) &&
                                $stable(update) && $stable(snap) && $stable(phase_clear))
    else $error("stalled result changed");

  // one transaction at a time: ready drops after an accepted input
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second input accepted while busy");

  a_no_update_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !update |-> target_level == '0 && step == '0 && !snap)
    else $error("fields set without update");

  a_snap_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && snap |-> update && step == '0)
    else $error("snap with nonzero step");

  a_clear_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid && phase_clear |-> !update)
    else $error("phase clear together with update");

endmodule

bind breakpoint_fader_automation fba_checker u_fba_checker (.*);
